@@ rtl/qmm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmm_pkg: shared definitions for the quad motor mixer
// Fixed-point widths, mixer constants and the square root unit status type.
// ----------------------------------------------------------------------------
package qmm_pkg;

	// Fixed-point format of setpoints and motor sums.
	localparam int FRAC_BITS = 12;
	localparam int DUTY_BITS = 8;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int DUTY_MAX  = (1 << DUTY_BITS) - 1;

	// Field and datapath widths.
	localparam int SP_W     = 14;
	localparam int MIX_W    = SP_W + 2;
	localparam int ROOT_W   = FRAC_BITS + 1;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int CNT_W    = 16;
	localparam int MOTORS   = 4;
	localparam int MOT_W    = $clog2(MOTORS);

	// Reset value of the timeout register.
	localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(1000);

	// Item kinds.
	localparam logic ACT_CMD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Status of the iterative square root unit.
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

@@ rtl/qmm_isqrt.sv @@
// ----------------------------------------------------------------------------
// qmm_isqrt: iterative integer square root
// Restoring digit recurrence, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module qmm_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [qmm_pkg::RAD_W-1:0]      radicand,
	output logic [qmm_pkg::ROOT_W-1:0]     root,
	output qmm_pkg::sqrt_stat_t            stat
);

	localparam int RW  = qmm_pkg::ROOT_W;
	localparam int SCW = $clog2(RW);

	logic [qmm_pkg::RAD_W-1:0] rad_q;
	logic [RW:0]               rem_q;
	logic [RW-1:0]             root_q;
	logic [SCW-1:0]            cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic [RW+1:0] diff;
	logic          fits;

	// One recurrence step: bring down two bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_q[RW-1:0], rad_q[qmm_pkg::RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
		diff   = rem_sh - trial;
	end

	// Sequencing: step count, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == SCW'(RW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + SCW'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= diff[RW:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/quad_motor_mixer_failsafe_top.sv @@
// ----------------------------------------------------------------------------
// quad_motor_mixer_failsafe_top: X-layout motor mixer with command timeout
// A valid command runs, per motor, a mix state and the shared square root unit
// (13 steps, then its done pulse), then a commit state. A new item is taken only
// when idle, after the last one is committed; ticks and rejected commands go
// straight to the commit state. A stalled result holds the commit state.
// Reset disarms the block, zeroes the duties and loads a timeout of 1000.
// ----------------------------------------------------------------------------
module quad_motor_mixer_failsafe_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic signed [qmm_pkg::SP_W-1:0]  thrust,
	input  logic signed [qmm_pkg::SP_W-1:0]  roll,
	input  logic signed [qmm_pkg::SP_W-1:0]  pitch,
	input  logic signed [qmm_pkg::SP_W-1:0]  yaw,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [qmm_pkg::DUTY_BITS-1:0]    duty_front_left,
	output logic [qmm_pkg::DUTY_BITS-1:0]    duty_front_right,
	output logic [qmm_pkg::DUTY_BITS-1:0]    duty_back_left,
	output logic [qmm_pkg::DUTY_BITS-1:0]    duty_back_right,
	output logic                             is_armed,
	output logic                             accepted,
	output logic                             timed_out,
	// Timeout register write port.
	input  logic                             cfg_wen,
	input  logic [qmm_pkg::CNT_W-1:0]        cfg_wdata
);

	localparam int SW = qmm_pkg::SP_W;
	localparam int MW = qmm_pkg::MIX_W;
	localparam int RW = qmm_pkg::ROOT_W;
	localparam int DW = qmm_pkg::DUTY_BITS;
	localparam int PW = RW + DW;
	localparam int NM = qmm_pkg::MOTORS;
	localparam int MTW = qmm_pkg::MOT_W;
	localparam int CW = qmm_pkg::CNT_W;

	localparam logic signed [SW-1:0] SP_ONE  = SW'(qmm_pkg::ONE);
	localparam logic signed [MW-1:0] MIX_ONE = MW'(qmm_pkg::ONE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [MTW-1:0]         mot_q;
	logic                   act_q;
	logic                   cmd_ok_q;
	logic signed [SW-1:0]   thr_q;
	logic signed [SW-1:0]   rol_q;
	logic signed [SW-1:0]   pit_q;
	logic signed [SW-1:0]   yaw_q;
	logic [DW-1:0]          new_duty_q [NM];
	logic [DW-1:0]          duty_q [NM];
	logic                   armed_q;
	logic [CW-1:0]          elapsed_q;
	logic [CW-1:0]          timeout_q;

	logic                   out_valid_q;
	logic [DW-1:0]          out_duty_q [NM];
	logic                   out_armed_q;
	logic                   out_acc_q;
	logic                   out_tmo_q;

	// Clamp a setpoint to plus or minus one.
	function automatic logic signed [SW-1:0] clamp_sp(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		if (v < -SP_ONE) begin
			r = -SP_ONE;
		end else if (v > SP_ONE) begin
			r = SP_ONE;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// X-layout mixing for one motor.
	function automatic logic signed [MW-1:0] mix_sum(
		input logic [MTW-1:0]      idx,
		input logic signed [SW-1:0] t,
		input logic signed [SW-1:0] r,
		input logic signed [SW-1:0] p,
		input logic signed [SW-1:0] y
	);
		logic signed [MW-1:0] te, re, pe, ye, s;
		te = MW'(t);
		re = MW'(r);
		pe = MW'(p);
		ye = MW'(y);
		case (idx)
			MTW'(0): s = te - re + pe + ye;
			MTW'(1): s = te + re + pe - ye;
			MTW'(2): s = te - re - pe - ye;
			default: s = te + re - pe + ye;
		endcase
		return s;
	endfunction

	// Mix and clamp the current motor, form the radicand for the root unit.
	logic signed [MW-1:0]   mix;
	logic [RW-1:0]          mclamp;
	logic [qmm_pkg::RAD_W-1:0] radicand;
	logic                   sqrt_start;
	logic [RW-1:0]          root;
	qmm_pkg::sqrt_stat_t    sqrt_stat;

	always_comb begin
		mix = mix_sum(mot_q, thr_q, rol_q, pit_q, yaw_q);
		if (mix < 0) begin
			mclamp = '0;
		end else if (mix > MIX_ONE) begin
			mclamp = RW'(qmm_pkg::ONE);
		end else begin
			mclamp = mix[RW-1:0];
		end
		radicand   = qmm_pkg::RAD_W'({mclamp, {qmm_pkg::FRAC_BITS{1'b0}}});
		sqrt_start = (state_q == ST_MIX);
	end

	qmm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.root     (root),
		.stat     (sqrt_stat)
	);

	// Scale the root to the duty range, truncating.
	logic [PW-1:0] prod;
	logic [DW-1:0] scaled;

	always_comb begin
		prod   = PW'(root) * PW'(qmm_pkg::DUTY_MAX);
		scaled = prod[qmm_pkg::FRAC_BITS +: DW];
	end

	// Next state for the commit cycle: arming, tick counting and failsafe.
	logic          in_xfer;
	logic          out_free;
	logic          thr_ok;
	logic [CW-1:0] tick_cnt;
	logic          nxt_armed;
	logic [CW-1:0] nxt_elapsed;
	logic [DW-1:0] nxt_duty [NM];
	logic          nxt_acc;
	logic          nxt_tmo;

	always_comb begin
		in_xfer  = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		thr_ok   = (thrust >= 0) && (thrust <= SP_ONE);
		tick_cnt = (elapsed_q == '1) ? elapsed_q : elapsed_q + CW'(1);

		nxt_armed   = armed_q;
		nxt_elapsed = elapsed_q;
		nxt_duty    = duty_q;
		nxt_acc     = 1'b0;
		nxt_tmo     = 1'b0;
		if (act_q == qmm_pkg::ACT_CMD) begin
			if (cmd_ok_q) begin
				nxt_armed   = 1'b1;
				nxt_elapsed = '0;
				nxt_duty    = new_duty_q;
				nxt_acc     = 1'b1;
			end
		end else if (armed_q) begin
			if (tick_cnt > timeout_q) begin
				nxt_armed   = 1'b0;
				nxt_elapsed = '0;
				for (int i = 0; i < NM; i++) begin
					nxt_duty[i] = '0;
				end
				nxt_tmo = 1'b1;
			end else begin
				nxt_elapsed = tick_cnt;
			end
		end
	end

	// Sequencer, block state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mot_q       <= '0;
			act_q       <= qmm_pkg::ACT_CMD;
			cmd_ok_q    <= 1'b0;
			thr_q       <= '0;
			rol_q       <= '0;
			pit_q       <= '0;
			yaw_q       <= '0;
			armed_q     <= 1'b0;
			elapsed_q   <= '0;
			timeout_q   <= qmm_pkg::TIMEOUT_RESET;
			out_valid_q <= 1'b0;
			out_armed_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_tmo_q   <= 1'b0;
			for (int i = 0; i < NM; i++) begin
				new_duty_q[i] <= '0;
				duty_q[i]     <= '0;
				out_duty_q[i] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				timeout_q <= cfg_wdata;
			end
			// The commit cycle reloads the result register itself.
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						act_q    <= action;
						cmd_ok_q <= thr_ok;
						thr_q    <= thrust;
						rol_q    <= clamp_sp(roll);
						pit_q    <= clamp_sp(pitch);
						yaw_q    <= clamp_sp(yaw);
						mot_q    <= '0;
						if ((action == qmm_pkg::ACT_CMD) && thr_ok) begin
							state_q <= ST_MIX;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MIX: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sqrt_stat.done) begin
						new_duty_q[mot_q] <= scaled;
						if (mot_q == MTW'(NM - 1)) begin
							state_q <= ST_FIN;
						end else begin
							mot_q   <= mot_q + MTW'(1);
							state_q <= ST_MIX;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						armed_q     <= nxt_armed;
						elapsed_q   <= nxt_elapsed;
						duty_q      <= nxt_duty;
						out_duty_q  <= nxt_duty;
						out_armed_q <= nxt_armed;
						out_acc_q   <= nxt_acc;
						out_tmo_q   <= nxt_tmo;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign duty_front_left  = out_duty_q[0];
	assign duty_front_right = out_duty_q[1];
	assign duty_back_left   = out_duty_q[2];
	assign duty_back_right  = out_duty_q[3];
	assign is_armed         = out_armed_q;
	assign accepted         = out_acc_q;
	assign timed_out        = out_tmo_q;

	// A failsafe stop always leaves the block disarmed with all duties at zero.
	a_tmo_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> !is_armed && !accepted &&
			duty_front_left == '0 && duty_front_right == '0 &&
			duty_back_left == '0 && duty_back_right == '0)
		else $error("failsafe result is not a full stop");

	// An accepted command always leaves the block armed.
	a_acc_arms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> is_armed)
		else $error("accepted command did not arm");

	// The root unit only runs while the sequencer waits for it.
	a_sqrt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_stat.busy |-> state_q == ST_ROOT)
		else $error("square root unit busy outside the root state");

	// A new result is loaded only by a commit, as the sequencer leaves the commit
	// state.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN && state_q == ST_IDLE)
		else $error("result loaded outside a commit");

endmodule
